@@ design/hash_partition_writer_defines.svh @@
// Assertion macros shared by the hash partition writer RTL.
`ifndef HASH_PARTITION_WRITER_DEFINES_SVH
`define HASH_PARTITION_WRITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HPW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HPW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/hpw_pkg.sv @@
// Package: sizes, types and helper functions of the hash partition writer.
package hpw_pkg;

    localparam int MAX_PARTITIONS = 256;
    localparam int MAX_SLOTS      = 65536;
    localparam int KEY_BITS       = 64;

    localparam int WORD_W  = 64;                           // key and payload words
    localparam int PART_W  = $clog2(MAX_PARTITIONS);       // partition index
    localparam int DIVR_W  = $clog2(MAX_PARTITIONS) + 1;   // partition count / remainder
    localparam int CNT_W   = $clog2(MAX_SLOTS) + 1;        // fill counter
    localparam int ADDR_W  = 24;                           // slot address
    localparam int PROD_W  = PART_W + CNT_W;               // partition * slots
    localparam int STEP_W  = $clog2(KEY_BITS + 1);         // bit-serial step count
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Configuration register indexes
    localparam logic REG_PART_COUNT = 1'b0;
    localparam logic REG_SLOTS      = 1'b1;

    localparam logic [DIVR_W-1:0] PART_COUNT_RST = DIVR_W'(1);
    localparam logic [CNT_W-1:0]  SLOTS_RST      = CNT_W'(MAX_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOOK,
        ST_PUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Zero partitions count as one; clamp to the table depth.
    function automatic logic [DIVR_W-1:0] eff_parts(input logic [DIVR_W-1:0] v);
        logic [DIVR_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIVR_W'(1);
        end else if (v > DIVR_W'(MAX_PARTITIONS)) begin
            r = DIVR_W'(MAX_PARTITIONS);
        end
        return r;
    endfunction

    // Clamp the capacity to the region size.
    function automatic logic [CNT_W-1:0] eff_slots(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v > CNT_W'(MAX_SLOTS)) begin
            r = CNT_W'(MAX_SLOTS);
        end
        return r;
    endfunction

endpackage

@@ design/hpw_mod_serial.sv @@
// Bit-serial remainder unit: key modulo partition count, one key bit per cycle.
module hpw_mod_serial (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hpw_pkg::WORD_W-1:0] i_key,
    input  logic [hpw_pkg::DIVR_W-1:0] i_divisor,
    output hpw_pkg::t_div_stat         o_stat,
    output logic [hpw_pkg::PART_W-1:0] o_rem
);
    import hpw_pkg::*;

    logic [KEY_BITS-1:0] r_shift;
    logic [DIVR_W-1:0]   r_rem;
    logic [STEP_W-1:0]   r_steps;
    logic                r_busy;
    logic                r_done;
    logic [DIVR_W-1:0]   trial;
    logic [DIVR_W-1:0]   n_rem;

    // Bring down the next key bit; subtract the divisor where it fits.
    always_comb begin
        trial = {r_rem[DIVR_W-2:0], r_shift[KEY_BITS-1]};
        n_rem = (trial >= i_divisor) ? (trial - i_divisor) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_steps <= STEP_W'(KEY_BITS);
            end else if (r_busy) begin
                r_steps <= r_steps - STEP_W'(1);
                if (r_steps == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_key[KEY_BITS-1:0];
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[KEY_BITS-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem[PART_W-1:0];

endmodule

@@ design/hpw_fill_table.sv @@
// Fill counter table: one counter per partition, registered read, valid bits.
module hpw_fill_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [hpw_pkg::PART_W-1:0] i_rd_idx,
    output logic [hpw_pkg::CNT_W-1:0]  o_rd_cnt,
    input  logic                       i_wr_en,
    input  logic [hpw_pkg::PART_W-1:0] i_wr_idx,
    input  logic [hpw_pkg::CNT_W-1:0]  i_wr_cnt
);
    import hpw_pkg::*;

    logic [CNT_W-1:0]          r_mem [MAX_PARTITIONS];
    logic [MAX_PARTITIONS-1:0] r_vld;
    logic [CNT_W-1:0]          r_rd_data;
    logic                      r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_cnt;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_idx];
            end
        end
    end

    assign o_rd_cnt = r_rd_vld ? r_rd_data : '0;

endmodule

@@ design/hash_partition_writer.sv @@
// Hash partition writer: routes each key/payload word to a partition slot.
// Words are handled one at a time: a new word is taken only once the previous result has been
//   handed to the output register, after the bit-serial remainder (one key bit at a time), the
//   counter read, the address multiply and the hand-over; a stalled output delays the hand-over.
// Reset (synchronous, active low) clears all fill counters at once through valid bits and
//   sets the partition count to 1 and the slot capacity to 65536.
`include "hash_partition_writer_defines.svh"

module hash_partition_writer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hpw_pkg::PADDR_W-1:0] paddr,
    input  logic [hpw_pkg::PDATA_W-1:0] pwdata,
    output logic [hpw_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    // input words
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [hpw_pkg::WORD_W-1:0]  i_key,
    input  logic [hpw_pkg::WORD_W-1:0]  i_payload,
    // result words
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [hpw_pkg::WORD_W-1:0]  o_key_out,
    output logic [hpw_pkg::WORD_W-1:0]  o_payload_out,
    output logic [hpw_pkg::PART_W-1:0]  o_partition_index,
    output logic [hpw_pkg::ADDR_W-1:0]  o_slot_address,
    output logic [hpw_pkg::CNT_W-1:0]   o_fill_after,
    output logic                        o_overflow
);
    import hpw_pkg::*;

    // Configuration registers
    logic [DIVR_W-1:0] r_part_cnt;
    logic [CNT_W-1:0]  r_slots;
    logic              cfg_wr;
    logic [DIVR_W-1:0] np;
    logic [CNT_W-1:0]  sl;

    // Control
    t_state    r_state;
    t_state    n_state;
    logic      in_acc;
    logic      div_start;
    logic      tbl_rd;
    logic      tbl_wr;
    logic      out_load;
    t_div_stat div_stat;

    // Word in flight
    logic [WORD_W-1:0] r_key;
    logic [WORD_W-1:0] r_payload;
    logic [PART_W-1:0] r_part;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_prod;
    logic              r_ovf;
    logic [PART_W-1:0] rem;
    logic [CNT_W-1:0]  rd_cnt;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  fill;

    // Output register
    logic              r_o_valid;
    logic [WORD_W-1:0] r_o_key;
    logic [WORD_W-1:0] r_o_payload;
    logic [PART_W-1:0] r_o_part;
    logic [ADDR_W-1:0] r_o_addr;
    logic [CNT_W-1:0]  r_o_fill;
    logic              r_o_ovf;

    // ---------------------------------------------------------------
    // Configuration port: always ready, decode on the word index only.
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_cnt <= PART_COUNT_RST;
            r_slots    <= SLOTS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_PART_COUNT: r_part_cnt <= pwdata[DIVR_W-1:0];
                REG_SLOTS:      r_slots    <= pwdata[CNT_W-1:0];
                default:        r_slots    <= r_slots;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PART_COUNT: prdata = PDATA_W'(r_part_cnt);
            REG_SLOTS:      prdata = PDATA_W'(r_slots);
            default:        prdata = '0;
        endcase
    end

    // Clamp registers to usable values; the user must keep them stable with a word in flight (unchecked).
    assign np = eff_parts(r_part_cnt);
    assign sl = eff_slots(r_slots);

    // ---------------------------------------------------------------
    // Sequencer: take a word, run the serial remainder, look up the
    // partition counter, then hand the result to the output register.
    // ---------------------------------------------------------------
    assign o_stall = (r_state != ST_IDLE);
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        tbl_rd    = 1'b0;
        tbl_wr    = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                // remainder is final in the cycle done is shown
                if (div_stat.done) begin
                    tbl_rd  = 1'b1;
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_PUT;
            end
            ST_PUT: begin
                // hold until the output register is free
                if (!r_o_valid || !i_stall) begin
                    out_load = 1'b1;
                    tbl_wr   = !r_ovf;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    hpw_mod_serial u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_key     (i_key),
        .i_divisor (np),
        .o_stat    (div_stat),
        .o_rem     (rem)
    );

    hpw_fill_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (tbl_rd),
        .i_rd_idx (rem),
        .o_rd_cnt (rd_cnt),
        .i_wr_en  (tbl_wr),
        .i_wr_idx (r_part),
        .i_wr_cnt (fill)
    );

    // Capture the word, the partition, then counter, overflow and base address.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key     <= i_key;
            r_payload <= i_payload;
        end
        if (tbl_rd) begin
            r_part <= rem;
        end
        if (r_state == ST_LOOK) begin
            r_cnt  <= rd_cnt;
            r_ovf  <= (rd_cnt >= sl);
            r_prod <= PROD_W'(r_part) * PROD_W'(sl);
        end
    end

    // A full partition keeps its counter and reports address zero.
    assign addr = r_ovf ? '0 : (r_prod[ADDR_W-1:0] + ADDR_W'(r_cnt));
    assign fill = r_ovf ? r_cnt : (r_cnt + CNT_W'(1));

    // ---------------------------------------------------------------
    // Output register: load from the sequencer, drop when taken.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_key     <= r_key;
            r_o_payload <= r_payload;
            r_o_part    <= r_part;
            r_o_addr    <= addr;
            r_o_fill    <= fill;
            r_o_ovf     <= r_ovf;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_key_out         = r_o_key;
    assign o_payload_out     = r_o_payload;
    assign o_partition_index = r_o_part;
    assign o_slot_address    = r_o_addr;
    assign o_fill_after      = r_o_fill;
    assign o_overflow        = r_o_ovf;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `HPW_ASSERT_NEXT(a_accept_starts_div, i_clk, i_rst_n, in_acc,
        (r_state == ST_DIV) && div_stat.busy, "accepted word did not start the remainder")
    `HPW_ASSERT_NOW(a_no_write_on_full, i_clk, i_rst_n, tbl_wr,
        !r_ovf && (r_cnt < sl), "counter written for a full partition")
    `HPW_ASSERT_NOW(a_ovf_addr_zero, i_clk, i_rst_n, o_valid && o_overflow,
        o_slot_address == '0, "overflow result carries a non-zero address")
    `HPW_ASSERT_NOW(a_placed_fill_nonzero, i_clk, i_rst_n, o_valid && !o_overflow,
        o_fill_after != '0, "placed word reports an empty partition")
    `HPW_ASSERT_NOW(a_done_only_in_div, i_clk, i_rst_n, div_stat.done,
        r_state == ST_DIV, "remainder finished outside its phase")

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the hash partition writer: directed and random tuple traffic.
`timescale 1ns / 100ps

module tb;

    import hpw_pkg::*;

    // Register byte addresses: register i lies at 4*i
    localparam logic [PADDR_W-1:0] ADDR_PART_COUNT = PADDR_W'(4 * REG_PART_COUNT);
    localparam logic [PADDR_W-1:0] ADDR_SLOTS      = PADDR_W'(4 * REG_SLOTS);

    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_WORDS   = 150;
    localparam int DRAIN_CYCLES  = 80;   // idle time after the final drain

    // Sender pacing and receiver back-pressure patterns
    typedef enum int {
        PACE_STEADY,
        PACE_BURSTY
    } t_pace;

    typedef enum int {
        BACKPRESSURE_NONE,
        BACKPRESSURE_LIGHT,
        BACKPRESSURE_HEAVY
    } t_backpressure;

    // One expected result word
    typedef struct {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] payload;
        logic [PART_W-1:0] part;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  fill;
        logic              ovf;
    } t_slot_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 i_valid;
    logic                 o_stall;
    logic [WORD_W-1:0]    i_key;
    logic [WORD_W-1:0]    i_payload;
    logic                 o_valid;
    logic                 i_stall;
    logic [WORD_W-1:0]    o_key_out;
    logic [WORD_W-1:0]    o_payload_out;
    logic [PART_W-1:0]    o_partition_index;
    logic [ADDR_W-1:0]    o_slot_address;
    logic [CNT_W-1:0]     o_fill_after;
    logic                 o_overflow;

    // Shadow of the block: configuration and per-partition fill counters
    logic [DIVR_W-1:0]    part_count_reg;
    logic [CNT_W-1:0]     slot_cap_reg;
    logic [CNT_W-1:0]     fill_count [MAX_PARTITIONS];

    t_slot_result         pending_slots [$];
    int                   fail_count;
    t_pace                send_pace;
    t_backpressure        stall_pattern;
    int                   burst_left;

    hash_partition_writer uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_key             (i_key),
        .i_payload         (i_payload),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_key_out         (o_key_out),
        .o_payload_out     (o_payload_out),
        .o_partition_index (o_partition_index),
        .o_slot_address    (o_slot_address),
        .o_fill_after      (o_fill_after),
        .o_overflow        (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Place one tuple in the shadow: pick the partition, take its counter, then advance it
    // unless the partition is already at capacity.
    function automatic t_slot_result place_tuple(input logic [WORD_W-1:0] k,
                                                 input logic [WORD_W-1:0] pl);
        t_slot_result      r;
        logic [DIVR_W-1:0] parts;
        logic [CNT_W-1:0]  cap;
        logic [CNT_W-1:0]  cnt;
        logic [PART_W-1:0] p;
        // A zero count means one partition; clamp anything above the table depth
        parts = part_count_reg;
        if (parts == '0) begin
            parts = DIVR_W'(1);
        end else if (parts > DIVR_W'(MAX_PARTITIONS)) begin
            parts = DIVR_W'(MAX_PARTITIONS);
        end
        cap = (slot_cap_reg > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slot_cap_reg;
        p = PART_W'(k % WORD_W'(parts));
        cnt = fill_count[p];
        r.key = k;
        r.payload = pl;
        r.part = p;
        r.addr = '0;
        r.fill = cnt;
        r.ovf = 1'b0;
        // A counter at or above capacity (also after the capacity was lowered) means full
        if (cnt >= cap) begin
            r.ovf = 1'b1;
        end else begin
            r.addr = ADDR_W'(32'(p) * 32'(cap) + 32'(cnt));
            r.fill = cnt + CNT_W'(1);
            fill_count[p] = r.fill;
        end
        return r;
    endfunction

    // Gap before the next word: none when steady, else bursts separated by random gaps
    function automatic int next_gap();
        int gap;
        gap = 0;
        if (send_pace == PACE_BURSTY) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                gap = $urandom_range(1, 90);
            end
            burst_left--;
        end
        return gap;
    endfunction

    // Offer one tuple word and hold it until accepted; valid stays high afterwards so that
    // back-to-back words need no second assignment in the same step.
    task automatic send_tuple(input logic [WORD_W-1:0] k, input logic [WORD_W-1:0] pl);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_key     <= k;
        i_payload <= pl;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_slots.push_back(place_tuple(k, pl));
    endtask

    // Drop valid and wait until every expected result word has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_slots.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] want);
        logic [PDATA_W-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            $error("prdata: expected %0d, got %0d", want, got);
            fail_count++;
        end
    endtask

    // Reconfigure only once the block is idle, then read both registers back
    task automatic set_config(input logic [DIVR_W-1:0] parts, input logic [CNT_W-1:0] cap);
        drain_results();
        write_reg(ADDR_PART_COUNT, PDATA_W'(parts));
        part_count_reg = parts;
        write_reg(ADDR_SLOTS, PDATA_W'(cap));
        slot_cap_reg = cap;
        read_reg(ADDR_PART_COUNT, PDATA_W'(part_count_reg));
        read_reg(ADDR_SLOTS, PDATA_W'(slot_cap_reg));
    endtask

    // Receiver: its own back-pressure pattern, changed at the falling edge
    initial begin
        int  run_left;
        logic level;
        run_left = 0;
        level = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run_left == 0) begin
                case (stall_pattern)
                    BACKPRESSURE_NONE: begin
                        level = 1'b0;
                        run_left = 8;
                    end
                    BACKPRESSURE_LIGHT: begin
                        level = ($urandom_range(0, 3) == 0);
                        run_left = $urandom_range(1, 4);
                    end
                    default: begin
                        level = ~level;
                        run_left = $urandom_range(1, 40);
                    end
                endcase
            end
            run_left--;
            i_stall <= level;
        end
    end

    // Result checker: compare every accepted result word with the oldest expectation
    initial begin
        t_slot_result exp_r;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
                if (pending_slots.size() == 0) begin
                    $error("unexpected result word: key %h", o_key_out);
                    fail_count++;
                end else begin
                    exp_r = pending_slots.pop_front();
                    if (o_key_out !== exp_r.key) begin
                        $error("key_out: expected %h, got %h", exp_r.key, o_key_out);
                        fail_count++;
                    end
                    if (o_payload_out !== exp_r.payload) begin
                        $error("payload_out: expected %h, got %h", exp_r.payload, o_payload_out);
                        fail_count++;
                    end
                    if (o_partition_index !== exp_r.part) begin
                        $error("partition_index: expected %0d, got %0d", exp_r.part,
                               o_partition_index);
                        fail_count++;
                    end
                    if (o_slot_address !== exp_r.addr) begin
                        $error("slot_address: expected %0d, got %0d", exp_r.addr,
                               o_slot_address);
                        fail_count++;
                    end
                    if (o_fill_after !== exp_r.fill) begin
                        $error("fill_after: expected %0d, got %0d", exp_r.fill, o_fill_after);
                        fail_count++;
                    end
                    if (o_overflow !== exp_r.ovf) begin
                        $error("overflow: expected %0d, got %0d", exp_r.ovf, o_overflow);
                        fail_count++;
                    end
                end
            end
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly full-width keys; some small keys to crowd a few partitions towards overflow
    function automatic logic [WORD_W-1:0] rand_key();
        logic [WORD_W-1:0] k;
        case ($urandom_range(0, 7))
            0: k = '1;
            1, 2: k = WORD_W'($urandom_range(0, 7));
            3: k = WORD_W'($urandom_range(0, 1023));
            default: k = rand_word();
        endcase
        return k;
    endfunction

    function automatic logic [DIVR_W-1:0] rand_part_count();
        logic [DIVR_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = DIVR_W'(1);
            2: v = DIVR_W'(MAX_PARTITIONS);
            3: v = DIVR_W'($urandom_range(MAX_PARTITIONS + 1, 511));
            default: v = DIVR_W'($urandom_range(2, MAX_PARTITIONS - 1));
        endcase
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] rand_slots();
        logic [CNT_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = CNT_W'(1);
            2: v = CNT_W'(MAX_SLOTS);
            3: v = CNT_W'($urandom_range(MAX_SLOTS + 1, 131071));
            4, 5: v = CNT_W'($urandom_range(2, 16));
            default: v = CNT_W'($urandom_range(17, MAX_SLOTS - 1));
        endcase
        return v;
    endfunction

    // Reset values readable, and every word lands in partition 0 at its running count
    task automatic test_reset_defaults();
        read_reg(ADDR_PART_COUNT, PDATA_W'(PART_COUNT_RST));
        read_reg(ADDR_SLOTS, PDATA_W'(SLOTS_RST));
        send_tuple('0, '0);
        send_tuple('1, '1);
        send_tuple(64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555);
        send_tuple(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    endtask

    // Largest table, zero count, a count above the table depth, and an odd divisor
    task automatic test_partition_extremes();
        set_config(DIVR_W'(MAX_PARTITIONS), CNT_W'(MAX_SLOTS));
        send_tuple(64'd255, rand_word());
        send_tuple(64'd256, rand_word());
        send_tuple('1, rand_word());
        send_tuple(64'hFFFF_FFFF_FFFF_FF00, rand_word());
        set_config('0, CNT_W'(MAX_SLOTS));
        send_tuple('1, rand_word());
        set_config(DIVR_W'(511), CNT_W'(MAX_SLOTS));
        send_tuple(64'h1FF, rand_word());
        set_config(DIVR_W'(3), CNT_W'(MAX_SLOTS));
        send_tuple('1, rand_word());
    endtask

    // Zero capacity, capacity above the region size, capacity below a counter, a full partition
    task automatic test_slot_limits();
        set_config(DIVR_W'(1), '0);
        send_tuple(rand_word(), rand_word());
        send_tuple(rand_word(), rand_word());
        set_config(DIVR_W'(MAX_PARTITIONS), CNT_W'(131071));
        send_tuple(64'd255, rand_word());
        send_tuple('1, rand_word());
        set_config(DIVR_W'(1), CNT_W'(1));
        send_tuple('0, rand_word());
        set_config(DIVR_W'(MAX_PARTITIONS), CNT_W'(2));
        send_tuple(64'd7, rand_word());
        send_tuple(64'd263, rand_word());
        send_tuple(64'd519, rand_word());
    endtask

    // Hold the sender back mid-stream until the block has returned everything
    task automatic test_sender_pause();
        set_config(DIVR_W'(16), CNT_W'(40));
        send_pace = PACE_BURSTY;
        stall_pattern = BACKPRESSURE_HEAVY;
        repeat (20) send_tuple(rand_key(), rand_word());
        drain_results();
        repeat (20) send_tuple(rand_key(), rand_word());
    endtask

    // Random tuples over a series of settings; the first phase runs with no idling at all
    task automatic test_random_traffic();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) begin
                set_config(DIVR_W'(MAX_PARTITIONS), CNT_W'(MAX_SLOTS));
                send_pace = PACE_STEADY;
                stall_pattern = BACKPRESSURE_NONE;
            end else begin
                set_config(rand_part_count(), rand_slots());
                send_pace = t_pace'($urandom_range(0, 1));
                stall_pattern = t_backpressure'($urandom_range(0, 2));
            end
            repeat (PHASE_WORDS) send_tuple(rand_key(), rand_word());
        end
    endtask

    // Stimulus: reset once, then run each test in turn and finish after the final drain
    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_valid       = 1'b0;
        i_key         = '0;
        i_payload     = '0;
        fail_count    = 0;
        burst_left    = 0;
        send_pace     = PACE_STEADY;
        stall_pattern = BACKPRESSURE_NONE;
        part_count_reg = PART_COUNT_RST;
        slot_cap_reg   = SLOTS_RST;
        foreach (fill_count[i]) fill_count[i] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_partition_extremes();
        test_slot_limits();
        test_sender_pause();
        test_random_traffic();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_slots.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
